// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL; they compile to nothing under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked property with reset masking.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: assertion failed");

// Condition that must never be seen on a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("%m: forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

// ----- rtl/core/stbs_pkg.sv -----
// Shared constants and types of the sorted table search block.
`timescale 1ns / 1ps

package stbs_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int KEY_W           = 64;
  localparam int IDX_W           = 10;
  localparam int CFG_W           = 11;
  localparam int POS_W           = 10;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // Strobes from the search engine to the key table.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

// ----- rtl/core/stbs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module stbs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/stbs_engine.sv -----
// Search sequencer: table writes, one probe per cycle, result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stbs_engine import stbs_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  localparam int ADDR_W     = $clog2(TABLE_DEPTH),
  localparam int CNT_W      = $clog2(TABLE_DEPTH + 1),
  localparam int CMP_W      = (CNT_W > IDX_W + 1) ? CNT_W : IDX_W + 1
) (
  input  logic              clk,
  input  logic              rst,
  // item channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              operation,
  input  logic [IDX_W-1:0]  index,
  input  logic [KEY_W-1:0]  key_value,
  // clamped entry count
  input  logic [CNT_W-1:0]  count,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic              found,
  output logic [POS_W-1:0]  position,
  // key table
  output mem_ctl_t          mem_ctl,
  output logic [ADDR_W-1:0] wr_addr,
  output logic [KEY_W-1:0]  wr_data,
  output logic [ADDR_W-1:0] rd_addr,
  input  logic [KEY_W-1:0]  rd_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEEK,
    ST_PROBE
  } state_t;

  state_t             state;
  logic [KEY_W-1:0]   key;
  logic [CNT_W-1:0]   low;
  logic [CNT_W-1:0]   hi;      // one past the inclusive upper bound
  logic [ADDR_W-1:0]  mid;

  logic               accept;
  logic               idx_ok;
  logic               active;
  logic               hit;
  logic               more;
  logic               slot_free;
  logic               done;
  logic [CNT_W-1:0]   mid_ext;
  logic [CNT_W-1:0]   low_next;
  logic [CNT_W-1:0]   hi_next;
  logic [CNT_W-1:0]   mid_wide;

  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign idx_ok    = CMP_W'(index) < CMP_W'(TABLE_DEPTH);
  assign active    = (state == ST_SEEK) || (state == ST_PROBE);
  assign slot_free = !out_valid || !out_stall;
  assign mid_ext   = CNT_W'(mid);

  assign wr_addr = ADDR_W'(index);
  assign wr_data = key_value;

  // Narrow the range from the entry just read, then pick the next probe.
  always_comb begin
    hit      = 1'b0;
    low_next = low;
    hi_next  = hi;
    if (state == ST_PROBE) begin
      if (key == rd_data) begin
        hit = 1'b1;
      end else if (key < rd_data) begin
        hi_next = mid_ext;
      end else begin
        low_next = mid_ext + CNT_W'(1);
      end
    end
    more     = !hit && (low_next < hi_next);
    mid_wide = low_next + ((hi_next - low_next - CNT_W'(1)) >> 1);
  end

  // search finished and the output register can take its beat
  assign done = active && !more && slot_free;

  assign rd_addr       = ADDR_W'(mid_wide);
  assign mem_ctl.rd_en = active && more;
  assign mem_ctl.wr_en = accept && (operation == OP_WRITE) && idx_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (done) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && (operation == OP_SEARCH)) begin
            key   <= key_value;
            low   <= '0;
            hi    <= count;
            state <= ST_SEEK;
          end
        end
        ST_SEEK, ST_PROBE: begin
          if (more) begin
            low   <= low_next;
            hi    <= hi_next;
            mid   <= ADDR_W'(mid_wide);
            state <= ST_PROBE;
          end else if (slot_free) begin
            found     <= hit;
            position  <= hit ? POS_W'(mid) : '0;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `ASSERT_CLK(a_range_order, clk, rst, (state != ST_IDLE) |-> (low <= hi))
  `ASSERT_CLK(a_mid_in_range, clk, rst,
              (state == ST_PROBE) |-> ((mid_ext >= low) && (mid_ext < hi)))
  `ASSERT_CLK(a_probe_has_read, clk, rst,
              ((state == ST_PROBE) && ($past(state) != ST_PROBE)) |-> $past(mem_ctl.rd_en))
  `ASSERT_NEVER(a_no_write_in_search, clk, rst, active && mem_ctl.wr_en)
  `ASSERT_CLK(a_miss_pos_zero, clk, rst, (out_valid && !found) |-> (position == '0))

endmodule

// ----- rtl/core/sorted_table_binary_search.sv -----
// Top level of the sorted table binary search block.
//
//  channel   dir  handshake               beat contents
//  --------  ---  ----------------------  ------------------------------------
//  cfg       in   cfg_valid / cfg_ready   entry_count (11 b)
//  item      in   in_valid / in_stall     operation, index (10 b), key_value (64 b)
//  result    out  out_valid / out_stall   found, position (10 b)
//
// A write beat lands its key in the table on the accepting edge. A search beat
// loads its key and range on the accepting edge; it makes P probes, P being at
// most ceil(log2(count + 1)), 11 for 1024 entries. The seek state issues the
// first read, then each probe cycle compares the registered table word and
// issues the next read, until the result is registered. The registered read of
// the key table RAM sets the probe loop. in_stall is high from the accepting
// edge of a search until its result enters the output register. A result
// waiting on out_stall does not block writes; a finished search holds until the
// output register frees. rst is synchronous: it clears the entry count, the
// sequencer and out_valid. Table contents are undefined until written.
`timescale 1ns / 1ps

module sorted_table_binary_search import stbs_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  // configuration
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] entry_count,
  // items
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             operation,
  input  logic [IDX_W-1:0] index,
  input  logic [KEY_W-1:0] key_value,
  // results
  output logic             out_valid,
  input  logic             out_stall,
  output logic             found,
  output logic [POS_W-1:0] position
);

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  logic [CFG_W-1:0]  count;
  logic [CMP_W-1:0]  count_ext;
  logic [CNT_W-1:0]  count_clamped;

  mem_ctl_t          mem_ctl;
  logic [ADDR_W-1:0] wr_addr;
  logic [KEY_W-1:0]  wr_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [KEY_W-1:0]  rd_data;

  // Always writable; software must touch it only while idle; the block never checks.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      count <= entry_count;
    end
  end

  // A count past the table size searches the whole table.
  assign count_ext     = CMP_W'(count);
  assign count_clamped = (count_ext > CMP_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                           : CNT_W'(count_ext);

  stbs_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_key_table (
    .clk     (clk),
    .wr_en   (mem_ctl.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (mem_ctl.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  stbs_engine #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .index     (index),
    .key_value (key_value),
    .count     (count_clamped),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .found     (found),
    .position  (position),
    .mem_ctl   (mem_ctl),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

endmodule

// ----- dv/sorted_table_binary_search_chk.sv -----
// Checker for the sorted table search block: mirrors the key table, predicts lookups, compares.
`timescale 1ns / 1ps

module sorted_table_binary_search_chk import stbs_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [CFG_W-1:0] entry_count,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic             operation,
  input  logic [IDX_W-1:0] index,
  input  logic [KEY_W-1:0] key_value,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic             found,
  input  logic [POS_W-1:0] position,
  output int               fail_count,
  output int               pending,
  output int               result_count,
  output int               hit_count
);

  typedef struct packed {
    logic             hit;
    logic [POS_W-1:0] pos;
  } lookup_t;

  logic [KEY_W-1:0] key_mirror [TABLE_DEPTH];
  logic [CFG_W-1:0] count_q;
  lookup_t          lookup_q [$];
  lookup_t          head;

  // Probe sequence over [lo, hi_ex); hi_ex is exclusive so it never wraps.
  function automatic lookup_t bsearch_table(input logic [KEY_W-1:0] key);
    int unsigned lo;
    int unsigned hi_ex;
    int unsigned mid;
    lookup_t     r;
    r     = '0;
    lo    = 0;
    hi_ex = (count_q > TABLE_DEPTH) ? TABLE_DEPTH : count_q;
    while (lo < hi_ex) begin
      mid = lo + (hi_ex - 1 - lo) / 2;
      if (key == key_mirror[mid]) begin
        r.hit = 1'b1;
        r.pos = mid[POS_W-1:0];
        lo    = hi_ex;
      end else if (key < key_mirror[mid]) begin
        hi_ex = mid;
      end else begin
        lo = mid + 1;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      count_q = '0;
      lookup_q.delete();
      fail_count   = 0;
      result_count = 0;
      hit_count    = 0;
    end else begin
      if (cfg_valid && cfg_ready) count_q = entry_count;
      // results first, so a search taken on this edge is not matched to them
      if (out_valid && !out_stall) begin
        result_count++;
        if (lookup_q.size() == 0) begin
          $error("result beat with no search outstanding: found %0d position %0d",
                 found, position);
          fail_count++;
        end else begin
          head = lookup_q.pop_front();
          if (found !== head.hit) begin
            $error("found: expected %0d, actual %0d", head.hit, found);
            fail_count++;
          end
          if (position !== head.pos) begin
            $error("position: expected %0d, actual %0d", head.pos, position);
            fail_count++;
          end
          if (head.hit) hit_count++;
        end
      end
      if (in_valid && !in_stall) begin
        if (operation == OP_WRITE) begin
          if (index < TABLE_DEPTH) key_mirror[index] = key_value;
        end else begin
          lookup_q.push_back(bsearch_table(key_value));
        end
      end
    end
    pending = lookup_q.size();
  end

endmodule

// ----- dv/sorted_table_binary_search_tb.sv -----
// Testbench top for the sorted table search block: stimulus, idling and verdict.
`timescale 1ns / 1ps

module sorted_table_binary_search_tb import stbs_pkg::*;;

  // run length in item beats; the idling regime changes at each third
  localparam int ITEM_TARGET = 1350;
  localparam int DEPTH       = TABLE_DEPTH_DEF;
  localparam logic [KEY_W-1:0] KEY_ONES = {KEY_W{1'b1}};

  logic             clk;
  logic             rst;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CFG_W-1:0] entry_count;
  logic             in_valid;
  logic             in_stall;
  logic             operation;
  logic [IDX_W-1:0] index;
  logic [KEY_W-1:0] key_value;
  logic             out_valid;
  logic             out_stall;
  logic             found;
  logic [POS_W-1:0] position;

  int fail_count;
  int pending;
  int result_count;
  int hit_count;

  // stimulus-side copy of the table, used to pick keys that hit
  logic [KEY_W-1:0] shadow  [DEPTH];
  bit               written [DEPTH];

  int items_sent;
  int n_writes;
  int n_searches;
  int n_settings;
  int tx_pct;
  int rx_pct;

  // phase bookkeeping for the main stimulus thread
  int               phase;
  int               span;
  int               n_look;
  int               w;
  int               leftover;
  bit               keep_old;
  logic [KEY_W-1:0] run_key;
  logic [KEY_W-1:0] next_key;
  logic [KEY_W-1:0] step;

  sorted_table_binary_search u_top (.*);

  sorted_table_binary_search_chk u_chk (.*);

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // result side: random stall per cycle at the current regime's rate
  always @(posedge clk) begin
    out_stall <= rst ? 1'b0 : ($urandom_range(99) < rx_pct);
  end

  function automatic logic [KEY_W-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  // Sender idles, then holds the beat until it is taken. Valid is only
  // lowered on idle cycles, never dropped between back-to-back beats.
  task automatic send_beat(input logic op, input logic [IDX_W-1:0] idx,
                           input logic [KEY_W-1:0] key);
    while ($urandom_range(99) < tx_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    index     <= idx;
    key_value <= key;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    // sender idles 21 / receiver 70, then swapped, then no idling
    if (items_sent < ITEM_TARGET / 3) begin
      tx_pct = 21;
      rx_pct = 70;
    end else if (items_sent < 2 * ITEM_TARGET / 3) begin
      tx_pct = 70;
      rx_pct = 21;
    end else begin
      tx_pct = 0;
      rx_pct = 0;
    end
  endtask

  task automatic put_key(input int idx, input logic [KEY_W-1:0] key);
    shadow[idx]  = key;
    written[idx] = 1'b1;
    n_writes++;
    send_beat(OP_WRITE, idx[IDX_W-1:0], key);
  endtask

  task automatic find_key(input logic [KEY_W-1:0] key);
    n_searches++;
    send_beat(OP_SEARCH, '0, key);
  endtask

  // Count register changes only with the block idle: all results in, then a
  // further wait in case the last beat was a write.
  task automatic set_count(input int n);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    cfg_valid   <= 1'b1;
    entry_count <= n[CFG_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  // Search key: half present keys, the rest near misses, random and extremes.
  function automatic logic [KEY_W-1:0] pick_key(input int n);
    int sel;
    logic [KEY_W-1:0] k;
    sel = $urandom_range(19);
    k   = rand_key();
    if (n > 0 && sel < 10)      k = shadow[$urandom_range(n - 1, 0)];
    else if (n > 0 && sel < 12) k = shadow[$urandom_range(n - 1, 0)] + KEY_W'(1);
    else if (n > 0 && sel < 14) k = shadow[$urandom_range(n - 1, 0)] - KEY_W'(1);
    else if (sel == 14)         k = '0;
    else if (sel == 15)         k = KEY_ONES;
    return k;
  endfunction

  initial begin
    rst         <= 1'b1;
    cfg_valid   <= 1'b0;
    entry_count <= '0;
    in_valid    <= 1'b0;
    operation   <= OP_WRITE;
    index       <= '0;
    key_value   <= '0;
    items_sent = 0;
    n_writes   = 0;
    n_searches = 0;
    n_settings = 0;
    tx_pct     = 21;
    rx_pct     = 70;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed ----
    // empty table straight out of reset
    find_key(64'd5);
    // sorted run with a triple duplicate and the two largest keys at the top
    put_key(0, 64'd1);
    put_key(1, 64'd5);
    put_key(2, 64'd5);
    put_key(3, 64'd5);
    put_key(4, 64'd100);
    put_key(5, 64'h8000_0000_0000_0000);
    put_key(6, KEY_ONES - KEY_W'(1));
    put_key(7, KEY_ONES);
    set_count(8);
    find_key(64'd0);          // below every entry: exclusive high bound falls to zero
    find_key(64'd1);
    find_key(64'd5);          // duplicate: first one the probes reach
    find_key(64'd3);          // miss between entries
    find_key(64'd100);
    find_key(64'h8000_0000_0000_0000);
    find_key(KEY_ONES);
    // single-entry table
    set_count(1);
    find_key(64'd0);
    find_key(64'd1);
    find_key(64'd2);
    // unsorted table: probes run unchanged
    set_count(8);
    put_key(4, 64'd0);
    find_key(64'd0);
    find_key(64'd100);

    // ---- random phases: refill a sorted prefix, set the count, search ----
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      if (phase == 2)                  span = DEPTH;
      else if ($urandom_range(9) == 0) span = 0;
      else if ($urandom_range(9) == 0) span = $urandom_range(200, 49);
      else                             span = $urandom_range(48, 1);

      // now and then search the old contents again if they cover the span
      keep_old = ($urandom_range(7) == 0);
      for (int i = 0; i < span; i++) if (!written[i]) keep_old = 1'b0;

      if (!keep_old && span > 0) begin
        // ascending keys; small steps give runs of duplicates, big steps
        // spread the keys, saturation piles duplicates on all ones
        run_key = rand_key() >> $urandom_range(63, 0);
        for (int i = 0; i < span; i++) begin
          put_key(i, run_key);
          if ($urandom_range(1) == 0) step = KEY_W'($urandom_range(3));
          else                        step = rand_key() >> $urandom_range(63, 8);
          next_key = run_key + step;
          run_key  = (next_key < run_key) ? KEY_ONES : next_key;
        end
        // broken sequence: one entry out of order
        if ($urandom_range(11) == 0) put_key($urandom_range(span - 1, 0), rand_key());
      end

      set_count(span);
      n_look = (span == DEPTH) ? 60 : $urandom_range(14, 4);
      for (int j = 0; j < n_look; j++) begin
        // stray write anywhere in the table between searches
        if ($urandom_range(12) == 0) put_key($urandom_range(DEPTH - 1, 0), rand_key());
        find_key(pick_key(span));
      end
      phase++;
    end

    // ---- drain ----
    in_valid <= 1'b0;
    @(posedge clk);
    for (w = 0; w < 5000 && pending != 0; w++) @(posedge clk);
    repeat (30) @(posedge clk);
    leftover = pending;
    if (leftover != 0) $error("%0d searches never answered", leftover);

    $display("Covered %0d beats: %0d table writes, %0d searches, %0d count settings (0..1024).",
             items_sent, n_writes, n_searches, n_settings);
    $display("%0d lookup results compared, %0d of them hits.", result_count, hit_count);
    if (fail_count == 0 && leftover == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // hard stop, far beyond the slowest correct run
  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
